### sv/sc2a_pkg.sv
package sc2a_pkg;

  // Key code space and fixed codes of scan-code set 1
  localparam int unsigned NUM_KEYS = 96;
  localparam int unsigned KEY_AW   = $clog2(NUM_KEYS);

  localparam logic [7:0]        PREFIX_EXT   = 8'hE0;
  localparam logic [KEY_AW-1:0] CODE_CAPS    = KEY_AW'(8'h3A);
  localparam logic [KEY_AW-1:0] CODE_NUM     = KEY_AW'(8'h45);
  localparam logic [KEY_AW-1:0] CODE_SCROLL  = KEY_AW'(8'h46);
  localparam logic [KEY_AW-1:0] CODE_LSHIFT  = KEY_AW'(8'h2A);
  localparam logic [KEY_AW-1:0] CODE_RSHIFT  = KEY_AW'(8'h36);
  localparam logic [KEY_AW-1:0] CODE_SLASH   = KEY_AW'(8'h35);

  localparam logic [1:0] MASK_PLAIN = 2'b01;
  localparam logic [1:0] MASK_EXT   = 2'b10;

  // Current keyboard state as seen by the translator
  typedef struct packed {
    logic ext;
    logic caps;
    logic num;
    logic scroll;
    logic lshift;
    logic rshift;
  } key_status_t;

  // State update computed for one scan word
  typedef struct packed {
    logic              ext;
    logic              caps;
    logic              num;
    logic              scroll;
    logic              wr_en;
    logic [KEY_AW-1:0] wr_addr;
    logic              wr_make;
    logic [1:0]        wr_mask;
  } key_update_t;

  // One result word
  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_code;
    logic       led_update;
    logic [2:0] led_bits;
  } result_t;

  // Unshifted column of the key table
  function automatic logic [6:0] plain_col(input logic [KEY_AW-1:0] code);
    logic [6:0] ch;
    unique case (code)
      7'h01: ch = 7'h1b;
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2d;
      7'h0D: ch = 7'h3d;
      7'h0E: ch = 7'h08;
      7'h0F: ch = 7'h09;
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6f;
      7'h19: ch = 7'h70;
      7'h1A: ch = 7'h5b;
      7'h1B: ch = 7'h5d;
      7'h1C: ch = 7'h0a;
      7'h1E: ch = 7'h61;
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6a;
      7'h25: ch = 7'h6b;
      7'h26: ch = 7'h6c;
      7'h27: ch = 7'h3b;
      7'h28: ch = 7'h27;
      7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5c;
      7'h2C: ch = 7'h7a;
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6e;
      7'h32: ch = 7'h6d;
      7'h33: ch = 7'h2c;
      7'h34: ch = 7'h2e;
      7'h35: ch = 7'h2f;
      7'h37: ch = 7'h2a;
      7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;
      7'h48: ch = 7'h38;
      7'h49: ch = 7'h39;
      7'h4A: ch = 7'h2d;
      7'h4B: ch = 7'h34;
      7'h4C: ch = 7'h35;
      7'h4D: ch = 7'h36;
      7'h4E: ch = 7'h2b;
      7'h4F: ch = 7'h31;
      7'h50: ch = 7'h32;
      7'h51: ch = 7'h33;
      7'h52: ch = 7'h30;
      7'h53: ch = 7'h2e;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // Shifted column of the key table
  function automatic logic [6:0] shift_col(input logic [KEY_AW-1:0] code);
    logic [6:0] ch;
    unique case (code)
      7'h01: ch = 7'h1b;
      7'h02: ch = 7'h21;
      7'h03: ch = 7'h40;
      7'h04: ch = 7'h23;
      7'h05: ch = 7'h24;
      7'h06: ch = 7'h25;
      7'h07: ch = 7'h5e;
      7'h08: ch = 7'h26;
      7'h09: ch = 7'h2a;
      7'h0A: ch = 7'h28;
      7'h0B: ch = 7'h29;
      7'h0C: ch = 7'h5f;
      7'h0D: ch = 7'h2b;
      7'h0E: ch = 7'h08;
      7'h0F: ch = 7'h09;
      7'h10: ch = 7'h51;
      7'h11: ch = 7'h57;
      7'h12: ch = 7'h45;
      7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;
      7'h15: ch = 7'h59;
      7'h16: ch = 7'h55;
      7'h17: ch = 7'h49;
      7'h18: ch = 7'h4f;
      7'h19: ch = 7'h50;
      7'h1A: ch = 7'h7b;
      7'h1B: ch = 7'h7d;
      7'h1C: ch = 7'h0a;
      7'h1E: ch = 7'h41;
      7'h1F: ch = 7'h53;
      7'h20: ch = 7'h44;
      7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;
      7'h23: ch = 7'h48;
      7'h24: ch = 7'h4a;
      7'h25: ch = 7'h4b;
      7'h26: ch = 7'h4c;
      7'h27: ch = 7'h3a;
      7'h28: ch = 7'h22;
      7'h29: ch = 7'h7e;
      7'h2B: ch = 7'h7c;
      7'h2C: ch = 7'h5a;
      7'h2D: ch = 7'h58;
      7'h2E: ch = 7'h43;
      7'h2F: ch = 7'h56;
      7'h30: ch = 7'h42;
      7'h31: ch = 7'h4e;
      7'h32: ch = 7'h4d;
      7'h33: ch = 7'h3c;
      7'h34: ch = 7'h3e;
      7'h35: ch = 7'h3f;
      7'h37: ch = 7'h2a;
      7'h39: ch = 7'h20;
      7'h4A: ch = 7'h2d;
      7'h4E: ch = 7'h2b;
      7'h53: ch = 7'h7f;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

### sv/sc2a_key_state.sv
module sc2a_key_state
  import sc2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  key_update_t upd,
  output key_status_t status
);

  logic ext;
  logic caps;
  logic num;
  logic scroll;
  logic lshift;
  logic rshift;

  // Lock flags, prefix flag and the plain pressed bits of both shift keys;
  // no other key's pressed bit reaches an output
  always_ff @(posedge clk) begin
    if (rst) begin
      ext    <= 1'b0;
      caps   <= 1'b0;
      num    <= 1'b0;
      scroll <= 1'b0;
      lshift <= 1'b0;
      rshift <= 1'b0;
    end else if (step) begin
      ext    <= upd.ext;
      caps   <= upd.caps;
      num    <= upd.num;
      scroll <= upd.scroll;
      if (upd.wr_en && (upd.wr_mask == MASK_PLAIN)) begin
        if (upd.wr_addr == CODE_LSHIFT) begin
          lshift <= upd.wr_make;
        end
        if (upd.wr_addr == CODE_RSHIFT) begin
          rshift <= upd.wr_make;
        end
      end
    end
  end

  // Only the plain shift keys are looked at
  assign status.ext    = ext;
  assign status.caps   = caps;
  assign status.num    = num;
  assign status.scroll = scroll;
  assign status.lshift = lshift;
  assign status.rshift = rshift;

endmodule

### sv/sc2a_xlate.sv
module sc2a_xlate
  import sc2a_pkg::*;
(
  input  logic [7:0]  scan_byte,
  input  key_status_t status,
  output key_update_t upd,
  output result_t     res
);

  logic [KEY_AW-1:0] code;
  logic              is_prefix;
  logic              in_range;
  logic              make;
  logic              hit_caps;
  logic              hit_num;
  logic              hit_scroll;
  logic              lshift_now;
  logic              rshift_now;
  logic              letter;
  logic              shift;
  logic [6:0]        plain_ch;
  logic [6:0]        shift_ch;
  logic [6:0]        ch;

  // Decode the scan word
  assign code       = scan_byte[KEY_AW-1:0];
  assign is_prefix  = (scan_byte == PREFIX_EXT);
  assign in_range   = (code < KEY_AW'(NUM_KEYS));
  assign make       = !is_prefix && in_range && !scan_byte[7];
  assign hit_caps   = make && (code == CODE_CAPS);
  assign hit_num    = make && (code == CODE_NUM);
  assign hit_scroll = make && (code == CODE_SCROLL);

  // Next state
  assign upd.ext     = is_prefix;
  assign upd.caps    = status.caps ^ hit_caps;
  assign upd.num     = status.num ^ hit_num;
  assign upd.scroll  = status.scroll ^ hit_scroll;
  assign upd.wr_en   = !is_prefix && in_range;
  assign upd.wr_addr = code;
  assign upd.wr_make = !scan_byte[7];
  assign upd.wr_mask = status.ext ? MASK_EXT : MASK_PLAIN;

  // Shift state including this make word
  assign lshift_now = status.lshift || (make && !status.ext && code == CODE_LSHIFT);
  assign rshift_now = status.rshift || (make && !status.ext && code == CODE_RSHIFT);
  assign plain_ch   = plain_col(code);
  assign shift_ch   = shift_col(code);
  assign letter     = (plain_ch >= 7'h61) && (plain_ch <= 7'h7a);
  assign shift      = (lshift_now || rshift_now) ^ (upd.caps && letter);

  // Column select; extended keys other than slash take the shifted column
  always_comb begin
    if (!make) begin
      ch = 7'h00;
    end else if (status.ext && code != CODE_SLASH) begin
      ch = shift_ch;
    end else if (shift) begin
      ch = shift_ch;
    end else begin
      ch = plain_ch;
    end
  end

  assign res.char_valid = (ch != 7'h00);
  assign res.char_code  = ch;
  assign res.led_update = hit_caps || hit_num || hit_scroll;
  assign res.led_bits   = {upd.caps, upd.num, upd.scroll};

endmodule

### sv/scancode_to_ascii_translator.sv
// Scan-code set 1 to ASCII translator.
// Input channel: in_valid / in_stall carry one scan byte per word (scan_byte).
// A 0xE0 byte arms the extended flag for the next byte; break codes clear the
// key's pressed bit; make codes set it, toggle NumLock/CapsLock/ScrollLock and
// are translated to ASCII.
// Output channel: out_valid / out_stall carry exactly one result word per input
// word: char_valid, char_code (0 when none), led_update and led_bits
// (bit2 caps, bit1 num, bit0 scroll, state after this byte).
// Path: an accepted word is held in the input register, then table lookup and
// state update write the result register.
// Throughput: one word per cycle while the output is not stalled; the key state is updated as each word advances.
// Reset (rst, synchronous): clears lock flags, the prefix flag, the shift key
// bits and the valid flags of both pipeline registers.
// When the receiver stalls, the result register holds its word and in_stall
// rises once the input register is also full.
module scancode_to_ascii_translator
  import sc2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       char_valid,
  output logic [6:0] char_code,
  output logic       led_update,
  output logic [2:0] led_bits
);

  logic        s1_valid;
  logic        s1_valid_next;
  logic [7:0]  s1_byte;
  logic        out_valid_next;
  logic        accept;
  logic        advance;
  key_status_t status;
  key_update_t upd;
  result_t     res;
  result_t     out_word;

  // Handshake
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid);
  assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid : 1'b0);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= scan_byte;
    end
  end

  sc2a_key_state u_state (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .upd    (upd),
    .status (status)
  );

  sc2a_xlate u_xlate (
    .scan_byte (s1_byte),
    .status    (status),
    .upd       (upd),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res;
    end
  end

  assign char_valid = out_word.char_valid;
  assign char_code  = out_word.char_code;
  assign led_update = out_word.led_update;
  assign led_bits   = out_word.led_bits;

endmodule

### sv/sc2a_checker.sv
module sc2a_checker
  import sc2a_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] scan_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       char_valid,
  input logic [6:0] char_code,
  input logic       led_update,
  input logic [2:0] led_bits
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // char_valid flags exactly a nonzero code
  a_char_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid == (char_code != 7'h00)))
    else $error("char_valid does not match char_code");

  // Input only backs up behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // An accepted word reaches the output when the output does not stall
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted word did not appear at the output");

endmodule

bind scancode_to_ascii_translator sc2a_checker u_sc2a_checker (.*);
